>>> src/ffrc_pkg.sv
// ----------------------------------------------------------------------------
// Flat-file row and column counter package
// Shared widths, character codes and the result word layout.
// ----------------------------------------------------------------------------
package ffrc_pkg;

    // Default counter widths.
    localparam int ROW_BITS_DEF = 32;
    localparam int COL_BITS_DEF = 16;

    // Widths of the fields as they appear on the ports.
    localparam int BYTE_W      = 8;
    localparam int ROW_OUT_W   = 32;
    localparam int COL_OUT_W   = 16;
    localparam int RESULT_W    = 2 * ROW_OUT_W + 2 * COL_OUT_W + 2;
    localparam int S_TDATA_W   = BYTE_W;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    // One result word, last field in the lowest bits.
    typedef struct packed {
        logic [ROW_OUT_W-1:0] mismatch_line;
        logic                 mismatch_now;
        logic                 inconsistent;
        logic [COL_OUT_W-1:0] title_columns;
        logic [COL_OUT_W-1:0] data_columns;
        logic [ROW_OUT_W-1:0] row_count;
    } ffrc_result_t;

endpackage

>>> src/flat_file_row_column_counter_top.sv
// ----------------------------------------------------------------------------
// Flat-file row and column counter
// Counts lines and fields of a text stream and flags the first data line
// whose field count differs from the first data line.
// ----------------------------------------------------------------------------
//  channel   direction  tdata contents (low bit first)
//  s_        in         text_byte[7:0]
//  m_        out        row_count[31:0], data_columns[47:32],
//                       title_columns[63:48], inconsistent[64],
//                       mismatch_now[65], mismatch_line[97:66], zero[103:98]
//  cfg_      in         field_delimiter[7:0], written when cfg_we is high
//
// An accepted byte is held in the input register, from which the counter
// logic loads the result register that drives the word on m_. One byte per
// clock is sustained while m_tready stays high. A stalled result holds its
// word; the input register holds one more byte and then s_tready drops until
// the result is taken.
// Reset is synchronous and clears all counters and the delimiter.
// ----------------------------------------------------------------------------
module flat_file_row_column_counter_top #(
    parameter int ROW_BITS = ffrc_pkg::ROW_BITS_DEF,
    parameter int COL_BITS = ffrc_pkg::COL_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ffrc_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // text_byte[7:0]
    input  logic [ffrc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // row_count, data_columns, title_columns, inconsistent, mismatch_now,
    // mismatch_line, zero fill
    output logic [ffrc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ffrc_pkg::*;

    logic              byte_valid;
    logic              byte_ready;
    logic [BYTE_W-1:0] byte_data;
    ffrc_result_t      result;

    ffrc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata[BYTE_W-1:0]),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data)
    );

    ffrc_core #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tdata = M_TDATA_W'(result);

endmodule

>>> src/ffrc_in_stage.sv
// ----------------------------------------------------------------------------
// Flat-file counter input stage
// Registers one incoming text byte and hands it to the counting core.
// ----------------------------------------------------------------------------
module ffrc_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffrc_pkg::BYTE_W-1:0]    s_byte,
    output logic                           byte_valid,
    input  logic                           byte_ready,
    output logic [ffrc_pkg::BYTE_W-1:0]    byte_data
);
    import ffrc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // The stage refills in the same cycle that the core drains it.
    assign s_tready = !valid_reg || byte_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (byte_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

>>> src/ffrc_core.sv
// ----------------------------------------------------------------------------
// Flat-file counter core
// Holds the line and field counters, classifies each byte, and registers
// one result word per byte.
// ----------------------------------------------------------------------------
module ffrc_core #(
    parameter int ROW_BITS = ffrc_pkg::ROW_BITS_DEF,
    parameter int COL_BITS = ffrc_pkg::COL_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ffrc_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  logic [ffrc_pkg::BYTE_W-1:0]    byte_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output ffrc_pkg::ffrc_result_t         m_result
);
    import ffrc_pkg::*;

    localparam logic [ROW_BITS-1:0] ROW_MAX = '1;
    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    logic [BYTE_W-1:0]   delim_reg;
    logic                has_content_reg, has_content_next;
    logic [COL_BITS-1:0] line_fields_reg, line_fields_next;
    logic [ROW_BITS-1:0] lines_seen_reg, lines_seen_next;
    logic [COL_BITS-1:0] data_cols_reg, data_cols_next;
    logic [COL_BITS-1:0] title_cols_reg, title_cols_next;
    logic                mismatch_reg, mismatch_next;
    logic [ROW_BITS-1:0] mismatch_at_reg, mismatch_at_next;
    logic                found_now;

    logic                out_valid_reg, out_valid_next;
    ffrc_result_t        result_reg, result_next;

    logic                fire;
    logic                is_nul, is_nl, is_sep;
    logic [COL_BITS-1:0] fields_inc;
    logic [COL_BITS-1:0] fields_closed;
    logic [63:0]         lines_wide, at_wide;
    logic [31:0]         data_wide, title_wide;

    assign byte_ready = !out_valid_reg || m_tready;
    assign fire       = byte_valid && byte_ready;

    assign is_nul = (byte_data == CHAR_NUL);
    assign is_nl  = (byte_data == CHAR_NL);
    assign is_sep = (delim_reg != CHAR_NUL) ? (byte_data == delim_reg)
                                            : (byte_data == CHAR_SPACE ||
                                               byte_data == CHAR_TAB);

    // Field counter with saturation at its maximum.
    assign fields_inc    = (line_fields_reg != COL_MAX) ? line_fields_reg + COL_BITS'(1)
                                                        : line_fields_reg;
    assign fields_closed = has_content_reg ? fields_inc : line_fields_reg;

    always_comb begin
        has_content_next = has_content_reg;
        line_fields_next = line_fields_reg;
        lines_seen_next  = lines_seen_reg;
        data_cols_next   = data_cols_reg;
        title_cols_next  = title_cols_reg;
        mismatch_next    = mismatch_reg;
        mismatch_at_next = mismatch_at_reg;
        found_now        = 1'b0;
        // A newline always ends the line, even when it is also the delimiter.
        priority if (is_nul) begin
            found_now = 1'b0;
        end else if (is_nl) begin
            if (lines_seen_reg == '0) begin
                title_cols_next = fields_closed;
            end else if (!mismatch_reg) begin
                if (data_cols_reg == '0) begin
                    data_cols_next = fields_closed;
                end else if (fields_closed != data_cols_reg) begin
                    mismatch_next    = 1'b1;
                    mismatch_at_next = lines_seen_reg;
                    found_now        = 1'b1;
                end
            end
            if (lines_seen_reg != ROW_MAX) begin
                lines_seen_next = lines_seen_reg + ROW_BITS'(1);
            end
            line_fields_next = '0;
            has_content_next = 1'b0;
        end else if (is_sep) begin
            // With a real delimiter empty fields count; blank runs collapse.
            if (delim_reg != CHAR_NUL || has_content_reg) begin
                line_fields_next = fields_inc;
            end
            has_content_next = 1'b0;
        end else begin
            has_content_next = 1'b1;
        end
    end

    always_comb begin
        lines_wide = 64'(lines_seen_next);
        at_wide    = 64'(mismatch_at_next);
        data_wide  = 32'(data_cols_next);
        title_wide = 32'(title_cols_next);
        result_next.row_count     = lines_wide[ROW_OUT_W-1:0];
        result_next.data_columns  = data_wide[COL_OUT_W-1:0];
        result_next.title_columns = title_wide[COL_OUT_W-1:0];
        result_next.inconsistent  = mismatch_next;
        result_next.mismatch_now  = found_now;
        result_next.mismatch_line = at_wide[ROW_OUT_W-1:0];
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg       <= CHAR_NUL;
            has_content_reg <= 1'b0;
            line_fields_reg <= '0;
            lines_seen_reg  <= '0;
            data_cols_reg   <= '0;
            title_cols_reg  <= '0;
            mismatch_reg    <= 1'b0;
            mismatch_at_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                delim_reg <= cfg_wdata;
            end
            if (fire) begin
                has_content_reg <= has_content_next;
                line_fields_reg <= line_fields_next;
                lines_seen_reg  <= lines_seen_next;
                data_cols_reg   <= data_cols_next;
                title_cols_reg  <= title_cols_next;
                mismatch_reg    <= mismatch_next;
                mismatch_at_reg <= mismatch_at_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = result_reg;

endmodule

>>> src/ffrc_checker.sv
// ----------------------------------------------------------------------------
// Flat-file counter port checker
// Watches the top-level ports and checks the result stream over time.
// ----------------------------------------------------------------------------
module ffrc_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ffrc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ffrc_pkg::*;

    ffrc_result_t res;
    logic         seen_incons_reg;
    logic         delivered;

    assign res       = m_tdata[RESULT_W-1:0];
    assign delivered = m_tvalid && m_tready;

    // Remembers that some delivered word already reported an inconsistency.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_incons_reg <= 1'b0;
        end else if (delivered && res.inconsistent) begin
            seen_incons_reg <= 1'b1;
        end
    end

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_first_flag_sets_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.mismatch_now |-> res.inconsistent)
        else $error("mismatch reported without inconsistency");

    a_latch_sticky_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_incons_reg |-> res.inconsistent && !res.mismatch_now)
        else $error("inconsistency cleared or reported twice");

endmodule

bind flat_file_row_column_counter_top ffrc_checker u_ffrc_checker (.*);
